### rtl/core/feq_pkg.sv
`timescale 1ns / 1ps

package feq_pkg;

  // defaults for the top level parameters
  localparam int QUEUE_DEPTH_DEFAULT     = 16;
  localparam int PAYLOAD_BYTES_DEFAULT   = 8;
  localparam int SIZE_WORD_BYTES_DEFAULT = 4;

  // opcodes
  localparam logic OP_ISSUE = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  // issue status codes
  localparam logic [1:0] ST_ADDED    = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_DROPPED  = 2'd3;

  // reserved event types
  localparam logic [7:0] TYPE_NONE      = 8'd0;
  localparam logic [7:0] TYPE_OVERFLOW  = 8'd1;
  localparam logic [7:0] TYPE_TOO_SMALL = 8'd2;

  // mask of the low n bytes of a 64-bit word
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

### rtl/core/filtered_event_queue_unit.sv
`timescale 1ns / 1ps

// bounded event queue with an overflow marker. an issue transfer (op 0) appends a typed
// event and its payload; once QUEUE_DEPTH entries are held one overflow marker (type 1)
// is appended and further issues are dropped until a poll frees space. a poll transfer
// (op 1) takes the head, or the oldest entry of the filter type when the filter is
// nonzero, and closes the gap behind it, unless the buffer is too small for the entry
// but holds the size word, in which case the entry stays queued. every input transfer
// gives exactly one result transfer. a poll compares entries up to the hit and, when it
// takes the hit out, moves each later entry down; compared and moved entries together
// never exceed the count. the entry store has a single registered read port: the
// sequencer reads and compares one entry a cycle and moves one entry a cycle. the input
// side stalls while an item is being worked; the finished result sits in an output
// register, so the next item may be taken while that result still waits. queue_enable
// is written through cfg_wr_en/cfg_wr_data and resets to 0 (issues rejected, polls
// return none). entry storage is not cleared at reset; only entries below the count are
// ever read.
module filtered_event_queue_unit #(
  parameter int QUEUE_DEPTH     = feq_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int PAYLOAD_BYTES   = feq_pkg::PAYLOAD_BYTES_DEFAULT,
  parameter int SIZE_WORD_BYTES = feq_pkg::SIZE_WORD_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_event_type,
  input  logic [63:0] in_payload,
  input  logic [3:0]  in_payload_length,
  input  logic [3:0]  in_buffer_length,
  input  logic [7:0]  in_filter_type,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_issue_status,
  output logic [7:0]  out_polled_type,
  output logic [63:0] out_data,
  output logic [3:0]  out_length,
  output logic [4:0]  out_queue_count
);

  localparam int SLOTS = QUEUE_DEPTH + 1;   // room for the overflow marker
  localparam int AW    = $clog2(SLOTS);
  localparam int PW    = PAYLOAD_BYTES * 8;

  // queue enable register
  logic enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_wr_en) begin
      enable_r <= cfg_wr_data;
    end
  end

  // store port wiring
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_type;
  logic [3:0]    wr_len;
  logic [PW-1:0] wr_payload;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_type;
  logic [3:0]    rd_len;
  logic [PW-1:0] rd_payload;

  // sequencer: issue append, filtered scan, gap closing, result register
  feq_ctrl #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .PAYLOAD_BYTES  (PAYLOAD_BYTES),
    .SIZE_WORD_BYTES(SIZE_WORD_BYTES)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .enable           (enable_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_event_type    (in_event_type),
    .in_payload       (in_payload),
    .in_payload_length(in_payload_length),
    .in_buffer_length (in_buffer_length),
    .in_filter_type   (in_filter_type),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_issue_status (out_issue_status),
    .out_polled_type  (out_polled_type),
    .out_data         (out_data),
    .out_length       (out_length),
    .out_queue_count  (out_queue_count),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_type          (wr_type),
    .wr_len           (wr_len),
    .wr_payload       (wr_payload),
    .rd_addr          (rd_addr),
    .rd_type          (rd_type),
    .rd_len           (rd_len),
    .rd_payload       (rd_payload)
  );

  // entry store: type, length and payload per slot
  feq_store #(
    .SLOTS(SLOTS),
    .PW   (PW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_type   (wr_type),
    .wr_len    (wr_len),
    .wr_payload(wr_payload),
    .rd_addr   (rd_addr),
    .rd_type   (rd_type),
    .rd_len    (rd_len),
    .rd_payload(rd_payload)
  );

endmodule

### rtl/core/feq_store.sv
`timescale 1ns / 1ps

module feq_store #(
  parameter int SLOTS = feq_pkg::QUEUE_DEPTH_DEFAULT + 1,
  parameter int PW    = feq_pkg::PAYLOAD_BYTES_DEFAULT * 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  logic [7:0]               wr_type,
  input  logic [3:0]               wr_len,
  input  logic [PW-1:0]            wr_payload,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output logic [7:0]               rd_type,
  output logic [3:0]               rd_len,
  output logic [PW-1:0]            rd_payload
);

  logic [7:0]    type_mem [SLOTS];
  logic [3:0]    len_mem  [SLOTS];
  logic [PW-1:0] pay_mem  [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      type_mem[wr_addr] <= wr_type;
      len_mem[wr_addr]  <= wr_len;
      pay_mem[wr_addr]  <= wr_payload;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_type    <= type_mem[rd_addr];
    rd_len     <= len_mem[rd_addr];
    rd_payload <= pay_mem[rd_addr];
  end

endmodule

### rtl/core/feq_ctrl.sv
`timescale 1ns / 1ps

module feq_ctrl #(
  parameter int QUEUE_DEPTH     = feq_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int PAYLOAD_BYTES   = feq_pkg::PAYLOAD_BYTES_DEFAULT,
  parameter int SIZE_WORD_BYTES = feq_pkg::SIZE_WORD_BYTES_DEFAULT,
  localparam int SLOTS = QUEUE_DEPTH + 1,
  localparam int AW    = $clog2(SLOTS),
  localparam int PW    = PAYLOAD_BYTES * 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          enable,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_op,
  input  logic [7:0]    in_event_type,
  input  logic [63:0]   in_payload,
  input  logic [3:0]    in_payload_length,
  input  logic [3:0]    in_buffer_length,
  input  logic [7:0]    in_filter_type,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    out_issue_status,
  output logic [7:0]    out_polled_type,
  output logic [63:0]   out_data,
  output logic [3:0]    out_length,
  output logic [4:0]    out_queue_count,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_type,
  output logic [3:0]    wr_len,
  output logic [PW-1:0] wr_payload,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_type,
  input  logic [3:0]    rd_len,
  input  logic [PW-1:0] rd_payload
);

  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [7:0]  filter_r, filter_nxt;
  logic [3:0]  blen_r, blen_nxt;
  logic [1:0]  res_status_r, res_status_nxt;
  logic [7:0]  res_type_r, res_type_nxt;
  logic [63:0] res_data_r, res_data_nxt;
  logic [3:0]  res_len_r, res_len_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [7:0]  out_type_r, out_type_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic [3:0]  out_len_r, out_len_nxt;
  logic [4:0]  out_count_r, out_count_nxt;

  logic          accept;
  logic [3:0]    plen_sat;
  logic [63:0]   plen_mask;
  logic [CW-1:0] idx_plus1;
  logic [CW-1:0] idx_plus2;
  logic          match;
  logic          at_last;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign plen_sat  = (in_payload_length > 4'(PAYLOAD_BYTES)) ? 4'(PAYLOAD_BYTES)
                                                             : in_payload_length;
  assign plen_mask = feq_pkg::byte_mask(plen_sat);
  assign idx_plus1 = CW'(idx_r) + CW'(1);
  assign idx_plus2 = CW'(idx_r) + CW'(2);
  assign match     = (filter_r == feq_pkg::TYPE_NONE) || (rd_type == filter_r);
  assign at_last   = (idx_plus1 == count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    filter_nxt     = filter_r;
    blen_nxt       = blen_r;
    res_status_nxt = res_status_r;
    res_type_nxt   = res_type_r;
    res_data_nxt   = res_data_r;
    res_len_nxt    = res_len_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_type_nxt   = out_type_r;
    out_data_nxt   = out_data_r;
    out_len_nxt    = out_len_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = AW'(count_r);
    wr_type        = in_event_type;
    wr_len         = plen_sat;
    wr_payload     = in_payload[PW-1:0] & plen_mask[PW-1:0];
    rd_addr        = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = feq_pkg::ST_ADDED;
          res_type_nxt   = feq_pkg::TYPE_NONE;
          res_data_nxt   = '0;
          res_len_nxt    = '0;
          state_nxt      = S_DONE;
          if (in_op == feq_pkg::OP_ISSUE) begin
            if (!enable) begin
              res_status_nxt = feq_pkg::ST_DISABLED;
            end else if (count_r == CW'(QUEUE_DEPTH)) begin
              // queue full: append the single overflow marker
              wr_en          = 1'b1;
              wr_type        = feq_pkg::TYPE_OVERFLOW;
              wr_len         = '0;
              wr_payload     = '0;
              count_nxt      = count_r + CW'(1);
              res_status_nxt = feq_pkg::ST_OVERFLOW;
            end else if (count_r > CW'(QUEUE_DEPTH)) begin
              res_status_nxt = feq_pkg::ST_DROPPED;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end else begin
            filter_nxt = in_filter_type;
            blen_nxt   = in_buffer_length;
            if (enable && (count_r != '0)) begin
              idx_nxt   = '0;
              rd_addr   = '0;
              state_nxt = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        if (match) begin
          if (rd_len > blen_r) begin
            res_type_nxt = feq_pkg::TYPE_TOO_SMALL;
          end else begin
            res_type_nxt = rd_type;
            res_data_nxt = 64'(rd_payload);
            res_len_nxt  = rd_len;
          end
          if ((rd_len > blen_r) && (blen_r >= 4'(SIZE_WORD_BYTES))) begin
            // size word only, entry stays queued
            res_data_nxt = 64'(rd_len);
            res_len_nxt  = 4'(SIZE_WORD_BYTES);
            state_nxt    = S_DONE;
          end else if (at_last) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_DONE;
          end else begin
            // close the gap from the entry after the hit
            rd_addr   = AW'(idx_plus1);
            state_nxt = S_SHIFT;
          end
        end else if (at_last) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = AW'(idx_plus1);
          rd_addr = AW'(idx_plus1);
        end
      end

      S_SHIFT: begin
        wr_en      = 1'b1;
        wr_addr    = idx_r;
        wr_type    = rd_type;
        wr_len     = rd_len;
        wr_payload = rd_payload;
        idx_nxt    = AW'(idx_plus1);
        if (idx_plus2 < count_r) begin
          rd_addr = AW'(idx_plus2);
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_type_nxt   = res_type_r;
          out_data_nxt   = res_data_r;
          out_len_nxt    = res_len_r;
          out_count_nxt  = 5'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
      filter_r     <= filter_nxt;
      blen_r       <= blen_nxt;
      res_status_r <= res_status_nxt;
      res_type_r   <= res_type_nxt;
      res_data_r   <= res_data_nxt;
      res_len_r    <= res_len_nxt;
      out_status_r <= out_status_nxt;
      out_type_r   <= out_type_nxt;
      out_data_r   <= out_data_nxt;
      out_len_r    <= out_len_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_issue_status = out_status_r;
  assign out_polled_type  = out_type_r;
  assign out_data         = out_data_r;
  assign out_length       = out_len_r;
  assign out_queue_count  = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SLOTS))
    else $error("queue count beyond storage");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CW'(idx_r) < count_r))
    else $error("scan index past last entry");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (idx_plus1 < count_r))
    else $error("shift source past last entry");

  a_overflow_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_status_r == feq_pkg::ST_OVERFLOW)
      |-> (count_r == CW'(QUEUE_DEPTH + 1)))
    else $error("overflow marker without full queue");

endmodule
